>>> src/dlpd_pkg.sv
// Shared types, codes and constants of the dual-lane payload digest.
package dlpd_pkg;

  localparam int OP_W   = 2;
  localparam int CTX_W  = 4;
  localparam int BYTE_W = 8;
  localparam int LANE_W = 64;

  localparam int NUM_CONTEXTS_DEF = 16;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [LANE_W-1:0] SEED_LANE0 = 64'hcbf29ce484222325;
  localparam logic [LANE_W-1:0] SEED_LANE1 = 64'h9E3779B97F4A7C15;
  // FNV prime is 2^40 + 0x1B3
  localparam int                PRIME_SHIFT = 40;
  localparam logic [8:0]        PRIME_LOW   = 9'h1B3;
  localparam logic [LANE_W-1:0] MIX_LANE1   = 64'hBF58476D1CE4E5B9;
  localparam int                FOLD_SHIFT  = 31;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_FINISH  = 2'd2,
    OP_DISCARD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_SEED    = 3'd0,
    CMD_UPDATE  = 3'd1,
    CMD_REPORT  = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_EMPTY   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CTX_W-1:0]   ctx;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic              live;
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/dlpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dlpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/dlpd_front.sv
// Front end: accepts items, drops those that do nothing, classifies the rest.
module dlpd_front #(
  parameter int NUM_CONTEXTS = dlpd_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [dlpd_pkg::OP_W-1:0]   operation,
  input  logic [dlpd_pkg::CTX_W-1:0]  context_index,
  input  logic [dlpd_pkg::BYTE_W-1:0] data_byte,
  input  logic                        init_busy,
  output logic                        push_valid,
  output dlpd_pkg::cmd_t              push_cmd,
  input  logic                        q_full
);
  import dlpd_pkg::*;

  logic      cmd_valid;
  cmd_t      cmd;
  cmd_t      cls_cmd;
  logic      cls_keep;
  logic      ctx_ok;
  logic      accept;
  op_t       op;

  assign op     = op_t'(operation);
  assign ctx_ok = (32'(context_index) < 32'(NUM_CONTEXTS));

  always_comb begin
    cls_cmd.ctx  = context_index;
    cls_cmd.data = data_byte;
    cls_cmd.kind = CMD_SEED;
    cls_keep     = ctx_ok;
    unique case (op)
      OP_BEGIN: begin
        cls_cmd.kind = CMD_SEED;
      end
      OP_BYTE: begin
        cls_cmd.kind = CMD_UPDATE;
      end
      OP_FINISH: begin
        // a finish always answers, even for a context out of range
        cls_keep     = 1'b1;
        cls_cmd.kind = ctx_ok ? CMD_REPORT : CMD_EMPTY;
      end
      OP_DISCARD: begin
        cls_cmd.kind = CMD_RELEASE;
      end
      default: begin
        cls_keep = 1'b0;
      end
    endcase
  end

  assign item_stall = init_busy | (cmd_valid & q_full);
  assign accept     = item_valid & ~item_stall;
  assign push_valid = cmd_valid;
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= cls_keep;
    end else if (cmd_valid && !q_full) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cls_cmd;
    end
  end

endmodule

>>> src/dlpd_queue.sv
// Short command queue between the front end and the digest engine.
module dlpd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  dlpd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output dlpd_pkg::cmd_t head_cmd
);
  import dlpd_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == (QAW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push_valid & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> src/dlpd_back.sv
// Digest engine: context store, lane arithmetic and the result register.
module dlpd_back #(
  parameter int NUM_CONTEXTS = dlpd_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  dlpd_pkg::cmd_t              head_cmd,
  output logic                        pop,
  output logic                        init_busy,
  output logic                        digest_valid,
  input  logic                        digest_stall,
  output logic [dlpd_pkg::LANE_W-1:0] lane0_digest,
  output logic [dlpd_pkg::LANE_W-1:0] lane1_digest,
  output logic                        digest_present
);
  import dlpd_pkg::*;

  localparam int AW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam logic [31:0] MIX_LO = MIX_LANE1[31:0];
  localparam logic [31:0] MIX_HI = MIX_LANE1[63:32];

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_FETCH  = 7'b0000100,
    S_ADD    = 7'b0001000,
    S_PROD   = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_REPORT = 7'b1000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [AW-1:0]       clr_cnt;
  cmd_kind_t           kind;
  logic [AW-1:0]       addr;
  logic [BYTE_W-1:0]   data;
  logic [LANE_W-1:0]   lane0;
  logic [LANE_W-1:0]   lane1;
  logic [LANE_W-1:0]   sum;
  logic [LANE_W-1:0]   plo;
  logic [31:0]         pcross;
  logic                present;

  logic [AW+CTX_W-1:0] head_ext;
  logic [AW-1:0]       head_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  entry_t              wr_entry;
  logic                rd_en;
  logic [ENTRY_W-1:0]  rd_raw;
  entry_t              rd_entry;
  logic [LANE_W-1:0]   base0;
  logic [LANE_W-1:0]   base1;
  logic [LANE_W-1:0]   mixed0;
  logic [LANE_W-1:0]   h0;
  logic                slot_free;

  assign head_ext  = (AW+CTX_W)'(head_cmd.ctx);
  assign head_addr = head_ext[AW-1:0];
  assign rd_entry  = entry_t'(rd_raw);
  assign base0     = rd_entry.live ? rd_entry.lane0 : SEED_LANE0;
  assign base1     = rd_entry.live ? rd_entry.lane1 : SEED_LANE1;
  assign mixed0    = base0 ^ LANE_W'(data);
  assign h0        = (mixed0 << PRIME_SHIFT) + mixed0 * LANE_W'(PRIME_LOW);
  assign slot_free = ~digest_valid | ~digest_stall;
  assign init_busy = (state == S_INIT);

  dlpd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_CONTEXTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (head_addr),
    .rd_data (rd_raw)
  );

  always_comb begin
    state_next     = state;
    pop            = 1'b0;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = addr;
    wr_entry.live  = 1'b0;
    wr_entry.lane0 = lane0;
    wr_entry.lane1 = plo + {pcross, 32'b0};
    unique case (state)
      S_INIT: begin
        // clear the live bits one entry per cycle
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        if (clr_cnt == AW'(NUM_CONTEXTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop     = 1'b1;
          wr_addr = head_addr;
          unique case (head_cmd.kind)
            CMD_SEED: begin
              wr_en          = 1'b1;
              wr_entry.live  = 1'b1;
              wr_entry.lane0 = SEED_LANE0;
              wr_entry.lane1 = SEED_LANE1;
            end
            CMD_RELEASE: begin
              wr_en = 1'b1;
            end
            CMD_UPDATE, CMD_REPORT: begin
              rd_en      = 1'b1;
              state_next = S_FETCH;
            end
            CMD_EMPTY: begin
              state_next = S_REPORT;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_FETCH: begin
        state_next = (kind == CMD_UPDATE) ? S_ADD : S_REPORT;
      end
      S_ADD: begin
        state_next = S_PROD;
      end
      S_PROD: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        wr_en         = 1'b1;
        wr_entry.live = 1'b1;
        state_next    = S_IDLE;
      end
      S_REPORT: begin
        if (slot_free) begin
          // finishing frees the context
          wr_en      = present;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      clr_cnt      <= '0;
      digest_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_REPORT && slot_free) begin
        digest_valid <= 1'b1;
      end else if (!digest_stall) begin
        digest_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head_valid) begin
      kind    <= head_cmd.kind;
      addr    <= head_addr;
      data    <= head_cmd.data;
      lane0   <= '0;
      lane1   <= '0;
      present <= 1'b0;
    end
    if (state == S_FETCH) begin
      if (kind == CMD_UPDATE) begin
        lane0 <= h0;
        lane1 <= base1;
      end else begin
        present <= rd_entry.live;
        lane0   <= rd_entry.live ? rd_entry.lane0 : '0;
        lane1   <= rd_entry.live ? rd_entry.lane1 : '0;
      end
    end
    if (state == S_ADD) begin
      sum <= lane1 + ((lane0 >> FOLD_SHIFT) ^ LANE_W'(data));
    end
    if (state == S_PROD) begin
      // low half of the 64x64 product from three 32x32 partial products
      plo    <= LANE_W'(sum[31:0]) * LANE_W'(MIX_LO);
      pcross <= 32'(sum[31:0] * MIX_HI) + 32'(sum[63:32] * MIX_LO);
    end
    if (state == S_REPORT && slot_free) begin
      lane0_digest   <= lane0;
      lane1_digest   <= lane1;
      digest_present <= present;
    end
  end

endmodule

>>> src/dual_lane_payload_digest.sv
// A finish item's result is registered at the digest outputs; a finish whose context
// index is at or above NUM_CONTEXTS skips the store read and goes straight to report.
// The engine takes one command at a time: a byte item passes read, FNV multiply, add,
// partial products and write back; begin and discard write from idle; finish reads, reports.
// A 4-entry command queue lets the front end keep accepting while the engine works.
// Reset: synchronous; afterwards every entry of the context store is cleared while
// items are stalled.
module dual_lane_payload_digest #(
  parameter int NUM_CONTEXTS = dlpd_pkg::NUM_CONTEXTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [dlpd_pkg::OP_W-1:0]   operation,
  input  logic [dlpd_pkg::CTX_W-1:0]  context_index,
  input  logic [dlpd_pkg::BYTE_W-1:0] data_byte,
  output logic                        digest_valid,
  input  logic                        digest_stall,
  output logic [dlpd_pkg::LANE_W-1:0] lane0_digest,
  output logic [dlpd_pkg::LANE_W-1:0] lane1_digest,
  output logic                        digest_present
);
  import dlpd_pkg::*;

  logic init_busy;
  logic push_valid;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  dlpd_front #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .context_index (context_index),
    .data_byte     (data_byte),
    .init_busy     (init_busy),
    .push_valid    (push_valid),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  dlpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dlpd_back #(
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .init_busy      (init_busy),
    .digest_valid   (digest_valid),
    .digest_stall   (digest_stall),
    .lane0_digest   (lane0_digest),
    .lane1_digest   (lane1_digest),
    .digest_present (digest_present)
  );

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    digest_valid && !digest_present |-> lane0_digest == '0 && lane1_digest == '0)
    else $error("empty digest carries nonzero lanes");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> item_stall)
    else $error("item taken during store clear");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !digest_valid)
    else $error("result shown during store clear");

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !pop)
    else $error("command popped during store clear");

endmodule

>>> verif/tb.sv
// Testbench for the dual-lane payload digest: per-context digest prediction and result checks.
`timescale 1ns / 100ps

module tb;
  import dlpd_pkg::*;

  localparam logic [LANE_W-1:0] FNV_PRIME      = 64'h100000001B3;
  localparam int                HOLDOFF_CYCLES = 200;
  localparam int                DRAIN_CYCLES   = 20;
  localparam int                MAX_REPORTS    = 10;

  typedef struct {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
    logic              present;
  } digest_t;

  class digest_scoreboard;
    bit                ctx_live [NUM_CONTEXTS_DEF];
    logic [LANE_W-1:0] ctx_lane0[NUM_CONTEXTS_DEF];
    logic [LANE_W-1:0] ctx_lane1[NUM_CONTEXTS_DEF];
    digest_t           expected_digests[$];
    int                errors;

    function new();
      errors = 0;
      foreach (ctx_live[i]) ctx_live[i] = 1'b0;
    endfunction

    function void seed_context(logic [CTX_W-1:0] ctx);
      ctx_live[ctx]  = 1'b1;
      ctx_lane0[ctx] = SEED_LANE0;
      ctx_lane1[ctx] = SEED_LANE1;
    endfunction

    function void note_item(op_t op, logic [CTX_W-1:0] ctx, logic [BYTE_W-1:0] b);
      digest_t           d;
      logic [LANE_W-1:0] h0;
      case (op)
        OP_BEGIN: begin
          seed_context(ctx);
        end
        OP_BYTE: begin
          // a byte on an empty context seeds it first
          if (!ctx_live[ctx]) seed_context(ctx);
          h0 = (ctx_lane0[ctx] ^ LANE_W'(b)) * FNV_PRIME;
          ctx_lane1[ctx] = (ctx_lane1[ctx] + ((h0 >> FOLD_SHIFT) ^ LANE_W'(b))) * MIX_LANE1;
          ctx_lane0[ctx] = h0;
        end
        OP_FINISH: begin
          d.present = ctx_live[ctx];
          d.lane0   = ctx_live[ctx] ? ctx_lane0[ctx] : '0;
          d.lane1   = ctx_live[ctx] ? ctx_lane1[ctx] : '0;
          expected_digests.push_back(d);
          ctx_live[ctx] = 1'b0;
        end
        OP_DISCARD: begin
          ctx_live[ctx] = 1'b0;
        end
      endcase
    endfunction

    function void check_digest(logic [LANE_W-1:0] l0, logic [LANE_W-1:0] l1, logic present);
      digest_t want;
      if (expected_digests.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected digest: lane0=%h lane1=%h present=%b", l0, l1, present);
        return;
      end
      want = expected_digests.pop_front();
      if (want.lane0 !== l0 || want.lane1 !== l1 || want.present !== present) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("digest mismatch: expected lane0=%h lane1=%h present=%b",
                   want.lane0, want.lane1, want.present);
          $display("                 actual   lane0=%h lane1=%h present=%b", l0, l1, present);
        end
      end
    endfunction

    function int pending();
      return expected_digests.size();
    endfunction
  endclass

  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                item_valid     = 1'b0;
  logic                item_stall;
  logic [OP_W-1:0]     operation      = OP_BEGIN;
  logic [CTX_W-1:0]    context_index  = '0;
  logic [BYTE_W-1:0]   data_byte      = '0;
  logic                digest_valid;
  logic                digest_stall   = 1'b0;
  logic [LANE_W-1:0]   lane0_digest;
  logic [LANE_W-1:0]   lane1_digest;
  logic                digest_present;

  bit                  calm           = 1'b0;
  bit                  flood          = 1'b0;
  bit                  holdoff_done   = 1'b0;
  logic [CTX_W-1:0]    last_ctx       = '0;
  digest_scoreboard    sb             = new();

  dual_lane_payload_digest dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .context_index  (context_index),
    .data_byte      (data_byte),
    .digest_valid   (digest_valid),
    .digest_stall   (digest_stall),
    .lane0_digest   (lane0_digest),
    .lane1_digest   (lane1_digest),
    .digest_present (digest_present)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: check accepted digests, stall at random, hold off once during the flood.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && digest_valid && !digest_stall)
        sb.check_digest(lane0_digest, lane1_digest, digest_present);
      if (flood && !holdoff_done) begin
        holdoff_done = 1'b1;
        digest_stall <= 1'b1;
        for (int n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clk);
      end else if (calm) begin
        digest_stall <= 1'b0;
      end else begin
        digest_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  task automatic send_item(op_t op, logic [CTX_W-1:0] ctx, logic [BYTE_W-1:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid    <= 1'b1;
    operation     <= op;
    context_index <= ctx;
    data_byte     <= b;
    do @(posedge clk); while (item_stall);
    sb.note_item(op, ctx, b);
    last_ctx = ctx;
  endtask

  task automatic send_random_item();
    int               r;
    op_t              op;
    logic [CTX_W-1:0] ctx;
    r = $urandom_range(99);
    if (r < 8)       op = OP_BEGIN;
    else if (r < 68) op = OP_BYTE;
    else if (r < 88) op = OP_FINISH;
    else             op = OP_DISCARD;
    // stay on the same context often so bytes hit back to back
    if ($urandom_range(99) < 45) ctx = last_ctx;
    else                         ctx = CTX_W'($urandom_range(NUM_CONTEXTS_DEF - 1));
    send_item(op, ctx, BYTE_W'($urandom_range(255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // seed only and finish, then finish on an empty context
    send_item(OP_BEGIN,   4'd0,  8'h00);
    send_item(OP_FINISH,  4'd0,  8'h00);
    send_item(OP_FINISH,  4'd1,  8'hff);
    // bytes on an empty context seed it
    send_item(OP_BYTE,    4'd2,  8'h00);
    send_item(OP_BYTE,    4'd2,  8'hff);
    send_item(OP_FINISH,  4'd2,  8'h00);
    // reseed a live context
    send_item(OP_BEGIN,   4'd15, 8'h00);
    send_item(OP_BYTE,    4'd15, 8'ha5);
    send_item(OP_BEGIN,   4'd15, 8'hff);
    send_item(OP_BYTE,    4'd15, 8'h5a);
    send_item(OP_FINISH,  4'd15, 8'h00);
    // discard on an empty context, and on a live one
    send_item(OP_DISCARD, 4'd3,  8'h00);
    send_item(OP_FINISH,  4'd3,  8'h00);
    send_item(OP_BEGIN,   4'd4,  8'h00);
    send_item(OP_BYTE,    4'd4,  8'h80);
    send_item(OP_DISCARD, 4'd4,  8'h00);
    send_item(OP_FINISH,  4'd4,  8'h00);
    // interleaved contexts
    send_item(OP_BYTE,    4'd7,  8'h01);
    send_item(OP_BYTE,    4'd8,  8'h7f);
    send_item(OP_FINISH,  4'd7,  8'h00);
    send_item(OP_FINISH,  4'd8,  8'h00);
    send_item(OP_FINISH,  4'd2,  8'h00);

    calm <= 1'b1;
    repeat (150) send_random_item();

    // fill the block while the receiver holds off
    flood <= 1'b1;
    repeat (40)
      send_item(($urandom_range(1) != 0) ? OP_FINISH : OP_BYTE,
                CTX_W'($urandom_range(NUM_CONTEXTS_DEF - 1)), BYTE_W'($urandom_range(255)));
    item_valid <= 1'b0;
    flood      <= 1'b0;
    calm       <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    repeat (560) send_random_item();
    item_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("PASSED: all results match");
    else                $display("FAILED: results differ");
    $finish;
  end

endmodule
